### rtl/core/max_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// max_priority_queue_assert.svh
// Assertion macros used by the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants and types of the sorted-chain priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int QueueDepth = 64;
  localparam int ValueWidth = 32;
  localparam int PrioWidth  = 16;
  localparam int CountWidth = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ActPush  = 2'd0,
    ActPop   = 2'd1,
    ActQuery = 2'd2
  } action_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [PrioWidth-1:0]  prio;
  } mpq_entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic       push;
    logic       pop;
    mpq_entry_t entry;
  } mpq_cmd_t;

endpackage

### rtl/core/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds an entry, inserts or shifts with its
// neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpq_cell import mpq_pkg::*; (
  input  logic       clk,
  input  mpq_cmd_t   cmd,
  input  logic       occupied,
  input  logic       left_gt,
  input  mpq_entry_t left_entry,
  input  mpq_entry_t right_entry,
  output logic       gt,
  output mpq_entry_t entry,
  output mpq_entry_t entry_next
);

  // Strict compare keeps equal priorities in arrival order: a new entry
  // lands behind every stored entry of the same priority.
  assign gt = !occupied || (cmd.entry.prio > entry.prio);

  always_comb begin
    entry_next = entry;
    if (cmd.push) begin
      if (gt) begin
        entry_next = left_gt ? left_entry : cmd.entry;
      end
    end else if (cmd.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### rtl/core/max_priority_queue.sv
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded priority queue built as a sorted chain of cells, head in cell 0.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | beat contents
//   in      | input     | in_valid / in_ready   | action, entry_value, entry_priority
//   out     | output    | out_valid / out_ready | head, count and status flags
//
// Each cell compares its priority with the pushed one and shifts or loads in
// the same edge, so one beat is accepted per cycle while in_ready is high.
// The result of a beat appears in the output register on the following cycle.
// in_ready falls only while a result waits in the output register and
// out_ready is low. Reset leaves the queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_priority_queue_assert.svh"

module max_priority_queue import mpq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            action,
  input  logic [ValueWidth-1:0] entry_value,
  input  logic [PrioWidth-1:0]  entry_priority,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ValueWidth-1:0] head_value,
  output logic [PrioWidth-1:0]  head_priority,
  output logic [CountWidth-1:0] entry_count,
  output logic                  is_empty,
  output logic                  push_dropped,
  output logic                  pop_empty_error
);

  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  is_push;
  logic                  is_pop;
  logic                  push_ok;
  logic                  pop_ok;
  mpq_cmd_t              cmd;
  logic [QueueDepth-1:0] occupied;
  logic [QueueDepth-1:0] gt;
  mpq_entry_t            cell_entry [QueueDepth];
  mpq_entry_t            cell_next  [QueueDepth];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CountWidth'(QueueDepth));

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    case (action_t'(action))
      ActPush: is_push = 1'b1;
      ActPop:  is_pop  = 1'b1;
      default: ;
    endcase
  end

  assign push_ok = accept && is_push && !full;
  assign pop_ok  = accept && is_pop && (count != '0);

  assign cmd.push        = push_ok;
  assign cmd.pop         = pop_ok;
  assign cmd.entry.value = entry_value;
  assign cmd.entry.prio  = entry_priority;

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CountWidth'(1);
    end else if (pop_ok) begin
      count_next = count - CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    assign occupied[i] = (CountWidth'(i) < count);

    if (i == 0) begin : g_first
      mpq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .left_gt    (1'b0),
        .left_entry ('0),
        .right_entry(cell_entry[i+1]),
        .gt         (gt[i]),
        .entry      (cell_entry[i]),
        .entry_next (cell_next[i])
      );
    end else if (i == QueueDepth - 1) begin : g_last
      mpq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .left_gt    (gt[i-1]),
        .left_entry (cell_entry[i-1]),
        .right_entry('0),
        .gt         (gt[i]),
        .entry      (cell_entry[i]),
        .entry_next (cell_next[i])
      );
    end else begin : g_mid
      mpq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .left_gt    (gt[i-1]),
        .left_entry (cell_entry[i-1]),
        .right_entry(cell_entry[i+1]),
        .gt         (gt[i]),
        .entry      (cell_entry[i]),
        .entry_next (cell_next[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The result reflects the queue after this beat, so the head comes from
  // the next value of cell 0.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (count_next == '0) begin
        head_value    <= '0;
        head_priority <= '0;
      end else begin
        head_value    <= cell_next[0].value;
        head_priority <= cell_next[0].prio;
      end
      entry_count     <= count_next;
      is_empty        <= (count_next == '0);
      push_dropped    <= is_push && full;
      pop_empty_error <= is_pop && (count == '0);
    end
  end

  `MPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CountWidth'(QueueDepth), "count above depth")
  `MPQ_ASSERT_NOW(a_head_sorted, count >= CountWidth'(2),
                  cell_entry[0].prio >= cell_entry[1].prio, "chain head out of order")
  `MPQ_ASSERT_NEXT(a_push_grows, push_ok, count == $past(count) + CountWidth'(1),
                   "accepted push did not grow the queue")
  `MPQ_ASSERT_NOW(a_drop_full, out_valid && push_dropped,
                  entry_count == CountWidth'(QueueDepth), "drop flagged below full")
  `MPQ_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (entry_count == '0),
                  "empty flag disagrees with count")

endmodule

### tb/max_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// max_priority_queue_tb
// Self-checking bench for the bounded priority queue. A local model of the
// queue predicts the status beat that follows every accepted command beat.
// Each output beat is checked field by field against the oldest prediction.
// Directed beats cover the empty, full and tied-priority corners. Random
// phases push the occupancy up and down, with idle gaps on the input side
// and stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_priority_queue_tb;
  import mpq_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int CycleLimit = 400000;
  localparam int MaxReported = 10;
  localparam int SlotBits = $clog2(QueueDepth);

  typedef struct packed {
    logic [ValueWidth-1:0] head_value;
    logic [PrioWidth-1:0]  head_prio;
    logic [CountWidth-1:0] count;
    logic                  empty;
    logic                  dropped;
    logic                  underflow;
  } queue_status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            action = ActQuery;
  logic [ValueWidth-1:0] entry_value = '0;
  logic [PrioWidth-1:0]  entry_priority = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ValueWidth-1:0] head_value;
  logic [PrioWidth-1:0]  head_priority;
  logic [CountWidth-1:0] entry_count;
  logic                  is_empty;
  logic                  push_dropped;
  logic                  pop_empty_error;

  // Local copy of the queue contents, in arrival order.
  logic [ValueWidth-1:0] model_value [QueueDepth];
  logic [PrioWidth-1:0]  model_prio  [QueueDepth];
  logic [CountWidth-1:0] model_count = '0;

  queue_status_t pending_status[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_stall_on = 1'b1;
  int unsigned   rx_stall_left = 0;

  max_priority_queue u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .entry_value     (entry_value),
    .entry_priority  (entry_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .head_value      (head_value),
    .head_priority   (head_priority),
    .entry_count     (entry_count),
    .is_empty        (is_empty),
    .push_dropped    (push_dropped),
    .pop_empty_error (pop_empty_error)
  );

  always #5 clk = ~clk;

  // First slot holding the strictly largest priority, so ties go to the oldest.
  function automatic int unsigned head_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < model_count; i++) begin
      if (model_prio[i] > model_prio[best]) best = i;
    end
    return best;
  endfunction

  function automatic queue_status_t apply_command(input logic [1:0] act,
                                                  input logic [ValueWidth-1:0] val,
                                                  input logic [PrioWidth-1:0] pri);
    queue_status_t st;
    int unsigned   h;
    st = '0;
    case (act)
      ActPush: begin
        if (model_count < QueueDepth) begin
          model_value[model_count[SlotBits-1:0]] = val;
          model_prio[model_count[SlotBits-1:0]]  = pri;
          model_count++;
        end else begin
          st.dropped = 1'b1;
        end
      end
      ActPop: begin
        if (model_count == 0) begin
          st.underflow = 1'b1;
        end else begin
          h = head_slot();
          for (int unsigned i = h; i + 1 < model_count; i++) begin
            model_value[i] = model_value[i+1];
            model_prio[i]  = model_prio[i+1];
          end
          model_count--;
        end
      end
      default: ;
    endcase
    if (model_count != 0) begin
      h = head_slot();
      st.head_value = model_value[h];
      st.head_prio  = model_prio[h];
    end
    st.count = model_count;
    st.empty = (model_count == 0);
    return st;
  endfunction

  // Output beats are checked before the prediction of this edge is queued;
  // a result never leaves in the same cycle its command is accepted.
  always @(posedge clk) begin
    queue_status_t exp_st;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported)
          $display("[%0t] unexpected status beat: value=%h prio=%h count=%0d",
                   $time, head_value, head_priority, entry_count);
      end else begin
        exp_st = pending_status.pop_front();
        if (head_value !== exp_st.head_value || head_priority !== exp_st.head_prio ||
            entry_count !== exp_st.count || is_empty !== exp_st.empty ||
            push_dropped !== exp_st.dropped || pop_empty_error !== exp_st.underflow) begin
          error_count++;
          if (error_count <= MaxReported)
            $display({"[%0t] mismatch: expected value=%h prio=%h count=%0d empty=%b ",
                      "dropped=%b underflow=%b, got value=%h prio=%h count=%0d ",
                      "empty=%b dropped=%b underflow=%b"}, $time,
                     exp_st.head_value, exp_st.head_prio, exp_st.count, exp_st.empty,
                     exp_st.dropped, exp_st.underflow, head_value, head_priority,
                     entry_count, is_empty, push_dropped, pop_empty_error);
        end
      end
    end
    if (!rst && in_valid && in_ready)
      pending_status.push_back(apply_command(action, entry_value, entry_priority));
  end

  // Output back-pressure: random stalls, mostly short, now and then long.
  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 99) < 25) begin
      rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** max_priority_queue: FAILED **");
    $finish;
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [PrioWidth-1:0] pick_prio();
    case ($urandom_range(0, 4))
      0, 1: return PrioWidth'($urandom_range(0, 3));
      2:    return ($urandom_range(0, 1) != 0) ? {PrioWidth{1'b1}} : '0;
      default: return PrioWidth'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_action(input int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < push_pct) return ActPush;
    r = $urandom_range(0, 19);
    if (r == 0) return ActUnused;
    if (r < 3) return ActQuery;
    return ActPop;
  endfunction

  task automatic send_beat(input logic [1:0] act, input logic [ValueWidth-1:0] val,
                           input logic [PrioWidth-1:0] pri);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    entry_value    <= val;
    entry_priority <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted status beat has come back.
  // The first edge lets the prediction of the last accepted beat be queued.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_directed();
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActQuery, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(ActUnused, 32'h1234_5678, 16'h0001);
    send_beat(ActPush, 32'hFFFF_FFFF, 16'h0000);
    send_beat(ActPush, 32'h0000_0000, 16'hFFFF);
    send_beat(ActPush, 32'hA5A5_0001, 16'hFFFF);
    send_beat(ActPush, 32'h5A5A_0002, 16'h8000);
    send_beat(ActQuery, 32'h0, 16'h0);
    send_beat(ActUnused, 32'hDEAD_BEEF, 16'h7FFF);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPush, 32'h0000_1111, 16'h0007);
    send_beat(ActPush, 32'h0000_2222, 16'h0007);
    send_beat(ActPush, 32'h0000_3333, 16'h0007);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActPop, 32'h0, 16'h0);
    send_beat(ActQuery, 32'h0, 16'h0);
    drain_results();
  endtask

  // Fill to capacity, push into the full queue, then empty it past the bottom.
  task automatic test_full_and_empty();
    repeat (QueueDepth) send_beat(ActPush, $urandom, pick_prio());
    repeat (3) send_beat(ActPush, $urandom, pick_prio());
    send_beat(ActQuery, $urandom, pick_prio());
    send_beat(ActPop, $urandom, pick_prio());
    send_beat(ActPush, $urandom, pick_prio());
    send_beat(ActPush, $urandom, pick_prio());
    repeat (QueueDepth + 1) send_beat(ActPop, $urandom, pick_prio());
    drain_results();
  endtask

  task automatic test_random_phases();
    int unsigned push_pct;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 50;
        default: push_pct = 25;
      endcase
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      repeat (100) send_beat(pick_action(push_pct), $urandom, pick_prio());
      if (phase == 4) drain_results();
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    drain_results();
  endtask

  task automatic test_back_to_back();
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    repeat (100) send_beat(pick_action(55), $urandom, pick_prio());
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_and_empty();
    test_random_phases();
    test_back_to_back();
    drain_results();
    if (error_count == 0 && pending_status.size() == 0) begin
      $display("** max_priority_queue: PASSED **");
    end else begin
      $display("** max_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
